// File: rtl/scp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants for the spline control point pipeline.
// ----------------------------------------------------------------------------
package scp_pkg;
	localparam int TENSION_BITS = 10;
	localparam int FA_EXTRA     = 16;
	localparam int FA_TOTAL     = 24;
	localparam int FRAC_W       = FA_TOTAL + 2;
	localparam logic [TENSION_BITS-1:0] TENSION_RESET = 10'd128;
endpackage
`default_nettype wire

// File: rtl/scp_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module scp_isqrt #(
	parameter int IN_W   = 32,
	parameter int SIDE_W = 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire                       in_valid,
	input  wire  [IN_W-1:0]           in_n,
	input  wire  [SIDE_W-1:0]         in_side,
	output logic                      out_valid,
	output logic [(IN_W+1)/2-1:0]     out_root,
	output logic [SIDE_W-1:0]         out_side
);
	localparam int RW = (IN_W + 1) / 2;
	localparam int NW = 2 * RW;

	logic [NW-1:0]     rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];
	logic [SIDE_W-1:0] side_s [RW+1];
	logic              vld_s  [RW+1];

	always_comb begin
		rem_s[0]  = NW'(in_n);
		root_s[0] = '0;
		side_s[0] = in_side;
		vld_s[0]  = in_valid;
	end

	for (genvar k = 0; k < RW; k++) begin : g_st
		localparam int B = RW - 1 - k;
		logic [NW+1:0] trial;
		logic [NW-1:0] rem_n;
		logic [RW-1:0] root_n;
		always_comb begin
			trial  = {2'b0, NW'(root_s[k]) << (B + 1)} + ({{NW{1'b0}}, 2'b1} << (2 * B));
			rem_n  = rem_s[k];
			root_n = root_s[k];
			if ({2'b0, rem_s[k]} >= trial) begin
				rem_n  = rem_s[k] - NW'(trial);
				root_n = root_s[k] | (RW'(1) << B);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_n;
				root_s[k+1] <= root_n;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];
endmodule
`default_nettype wire

// File: rtl/scp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module scp_div #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 16,
	parameter int SIDE_W = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 in_valid,
	input  wire  [NUM_W-1:0]    in_num,
	input  wire  [DEN_W-1:0]    in_den,
	input  wire  [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [NUM_W-1:0]    out_quo,
	output logic [SIDE_W-1:0]   out_side
);
	logic [DEN_W-1:0]  rem_s  [NUM_W+1];
	logic [NUM_W-1:0]  quo_s  [NUM_W+1];
	logic [DEN_W-1:0]  den_s  [NUM_W+1];
	logic [SIDE_W-1:0] side_s [NUM_W+1];
	logic              vld_s  [NUM_W+1];

	always_comb begin
		rem_s[0]  = '0;
		quo_s[0]  = in_num;
		den_s[0]  = in_den;
		side_s[0] = in_side;
		vld_s[0]  = in_valid;
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		logic [DEN_W:0]   sh;
		logic [DEN_W-1:0] rem_n;
		logic             qb;
		always_comb begin
			sh    = {rem_s[k], quo_s[k][NUM_W-1]};
			qb    = (sh >= {1'b0, den_s[k]});
			rem_n = qb ? DEN_W'(sh - {1'b0, den_s[k]}) : sh[DEN_W-1:0];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_n;
				quo_s[k+1]  <= {quo_s[k][NUM_W-2:0], qb};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign out_quo   = quo_s[NUM_W];
	assign out_side  = side_s[NUM_W];
endmodule
`default_nettype wire

// File: rtl/spline_control_points_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spline_control_points_top
// Bezier control points around the middle of three waypoints.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                 | tuser
// s_axis  | in  | p0_x p0_y p1_x p1_y p2_x p2_y            | -
// m_axis  | out | c1_x c1_y c2_x c2_y                       | clipped
// cfg     | in  | tension (10 bit), write on cfg_wr_en      | -
// One word per cycle while the output stage is empty or taken. A word passes
// the square roots, then the fraction divider, one bit per stage each.
// Reset clears all valid bits and loads tension 128.
// The whole pipe advances whenever the output stage is empty or taken.
module spline_control_points_top #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 4
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire  [scp_pkg::TENSION_BITS-1:0]     cfg_wr_data,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
	input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// c1_x, c1_y, c2_x, c2_y
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
	// clipped
	output logic                                 m_axis_tuser
);
	import scp_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int SH   = (CW > 30) ? CW - 30 : 0;
	localparam int DW   = CW - SH;
	localparam int QW   = 2 * DW + 1;
	localparam int RW   = (QW + 1) / 2;
	localparam int SW   = RW + 1;
	localparam int NUMW = TENSION_BITS + RW + FA_EXTRA;
	localparam int PW   = CW + 1 + FRAC_W;
	localparam int OW   = ((4*CW+7)/8)*8;
	localparam int SIDE = 2*CW + 2*(CW+1) + TENSION_BITS;

	typedef struct packed {
		logic signed [CW-1:0] x1, y1;
		logic signed [CW:0]   cx, cy;
		logic [TENSION_BITS-1:0] t;
	} side_t;

	logic en;
	logic [TENSION_BITS-1:0] tension_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= TENSION_RESET;
		end else if (cfg_wr_en) begin
			tension_q <= cfg_wr_data;
		end
	end

	// stage 1: differences
	logic v_s1;
	logic [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	side_t sd_s1;
	logic signed [CW-1:0] ix0, iy0, ix1, iy1, ix2, iy2;
	assign {iy2, ix2, iy1, ix1, iy0, ix0} = s_axis_tdata[6*CW-1:0];

	function automatic logic [CW:0] adiff(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		d = CW'(0) + ({a[CW-1], a} - {b[CW-1], b});
		return d[CW] ? CW'(0) - d : d;
	endfunction

	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= DW'(adiff(ix1, ix0) >> SH);
			ay_s1    <= DW'(adiff(iy1, iy0) >> SH);
			bx_s1    <= DW'(adiff(ix2, ix1) >> SH);
			by_s1    <= DW'(adiff(iy2, iy1) >> SH);
			sd_s1.x1 <= ix1;
			sd_s1.y1 <= iy1;
			sd_s1.cx <= {ix2[CW-1], ix2} - {ix0[CW-1], ix0};
			sd_s1.cy <= {iy2[CW-1], iy2} - {iy0[CW-1], iy0};
			sd_s1.t  <= tension_q;
		end
	end

	// stage 2: squares
	logic v_s2;
	logic [2*DW-1:0] sax_s2, say_s2, sbx_s2, sby_s2;
	side_t sd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sax_s2 <= ax_s1 * ax_s1;
			say_s2 <= ay_s1 * ay_s1;
			sbx_s2 <= bx_s1 * bx_s1;
			sby_s2 <= by_s1 * by_s1;
			sd_s2  <= sd_s1;
		end
	end

	// stage 3: sums of squares
	logic v_s3;
	logic [QW-1:0] qa_s3, qb_s3;
	side_t sd_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			qa_s3 <= QW'(sax_s2) + QW'(say_s2);
			qb_s3 <= QW'(sbx_s2) + QW'(sby_s2);
			sd_s3 <= sd_s2;
		end
	end

	logic          rv;
	logic [RW-1:0] ra, rb;
	logic [RW+SIDE-1:0] rside;
	side_t sd_r;
	logic [RW-1:0] rb_unused_side;

	scp_isqrt #(.IN_W(QW), .SIDE_W(SIDE)) u_sqrt_a (
		.clk, .arst_n, .en, .in_valid(v_s3), .in_n(qa_s3), .in_side(sd_s3),
		.out_valid(rv), .out_root(ra), .out_side(sd_r)
	);
	logic rv_b;
	logic [0:0] dummy_side;
	scp_isqrt #(.IN_W(QW), .SIDE_W(1)) u_sqrt_b (
		.clk, .arst_n, .en, .in_valid(v_s3), .in_n(qb_s3), .in_side(1'b0),
		.out_valid(rv_b), .out_root(rb), .out_side(dummy_side)
	);
	assign rside = {ra, sd_r};
	assign rb_unused_side = rb;

	// stage 4: numerator and total distance
	logic v_s4;
	logic [NUMW-1:0] num_s4;
	logic [SW-1:0]   s_s4;
	side_t sd_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= rv & rv_b & ~dummy_side[0];
		end
	end
	logic [SW-1:0] ssum;
	assign ssum = SW'(rside[RW+SIDE-1:SIDE]) + SW'(rb_unused_side);
	always_ff @(posedge clk) begin
		if (en) begin
			s_s4   <= ssum;
			num_s4 <= ((NUMW'(sd_r.t) * NUMW'(ra)) << FA_EXTRA) + NUMW'(ssum >> 1);
			sd_s4  <= sd_r;
		end
	end

	logic dv;
	logic [NUMW-1:0] quo;
	logic [SIDE+SW-1:0] dside;
	side_t sd_d;
	logic [SW-1:0] s_d;
	scp_div #(.NUM_W(NUMW), .DEN_W(SW), .SIDE_W(SIDE+SW)) u_div (
		.clk, .arst_n, .en, .in_valid(v_s4), .in_num(num_s4), .in_den(s_s4),
		.in_side({s_s4, sd_s4}), .out_valid(dv), .out_quo(quo), .out_side(dside)
	);
	assign sd_d = dside[SIDE-1:0];
	assign s_d  = dside[SIDE+SW-1:SIDE];

	// stage 5: fractions and chord magnitudes
	logic v_s5;
	logic [FRAC_W-1:0] fa_s5, fb_s5;
	logic [CW:0] mx_s5, my_s5;
	logic nx_s5, ny_s5;
	side_t sd_s5;
	logic [FRAC_W-1:0] full, fa_c;
	assign full = FRAC_W'(sd_d.t) << FA_EXTRA;
	always_comb begin
		fa_c = '0;
		if (s_d != '0) begin
			fa_c = (quo > NUMW'(full)) ? full : FRAC_W'(quo);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fa_s5 <= fa_c;
			fb_s5 <= (s_d != '0) ? full - fa_c : '0;
			nx_s5 <= sd_d.cx[CW];
			ny_s5 <= sd_d.cy[CW];
			mx_s5 <= sd_d.cx[CW] ? (CW+1)'(0) - sd_d.cx : sd_d.cx;
			my_s5 <= sd_d.cy[CW] ? (CW+1)'(0) - sd_d.cy : sd_d.cy;
			sd_s5 <= sd_d;
		end
	end

	// stage 6: products
	logic v_s6;
	logic [PW-1:0] pax_s6, pay_s6, pbx_s6, pby_s6;
	logic nx_s6, ny_s6;
	side_t sd_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pax_s6 <= PW'(mx_s5) * PW'(fa_s5);
			pay_s6 <= PW'(my_s5) * PW'(fa_s5);
			pbx_s6 <= PW'(mx_s5) * PW'(fb_s5);
			pby_s6 <= PW'(my_s5) * PW'(fb_s5);
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			sd_s6  <= sd_s5;
		end
	end

	// stage 7: rounded signed offsets
	localparam int EW = PW - FA_TOTAL + 2;
	logic v_s7;
	logic signed [EW-1:0] ox_a_s7, oy_a_s7, ox_b_s7, oy_b_s7;
	side_t sd_s7;
	function automatic logic signed [EW-1:0] rnd(logic [PW-1:0] p, logic n);
		logic [PW-1:0] r;
		logic [EW-1:0] m;
		r = (p + (PW'(1) << (FA_TOTAL - 1))) >> FA_TOTAL;
		m = EW'(r);
		return n ? EW'(0) - m : m;
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ox_a_s7 <= rnd(pax_s6, nx_s6);
			oy_a_s7 <= rnd(pay_s6, ny_s6);
			ox_b_s7 <= rnd(pbx_s6, nx_s6);
			oy_b_s7 <= rnd(pby_s6, ny_s6);
			sd_s7   <= sd_s6;
		end
	end

	// stage 8: add, saturate, output register
	localparam int AW = EW + 1;
	function automatic logic [CW:0] sat(logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi, lo;
		hi = AW'((64'sd1 <<< (CW - 1)) - 1);
		lo = -hi - AW'(1);
		if (v > hi) return {1'b1, hi[CW-1:0]};
		if (v < lo) return {1'b1, lo[CW-1:0]};
		return {1'b0, v[CW-1:0]};
	endfunction
	logic [CW:0] r0, r1, r2, r3;
	logic signed [AW-1:0] ex1, ey1;
	assign ex1 = AW'(sd_s7.x1);
	assign ey1 = AW'(sd_s7.y1);
	assign r0 = sat(ex1 - AW'(ox_a_s7));
	assign r1 = sat(ey1 - AW'(oy_a_s7));
	assign r2 = sat(ex1 + AW'(ox_b_s7));
	assign r3 = sat(ey1 + AW'(oy_b_s7));

	assign en = ~m_axis_tvalid | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= OW'({r3[CW-1:0], r2[CW-1:0], r1[CW-1:0], r0[CW-1:0]});
			m_axis_tuser <= r0[CW] | r1[CW] | r2[CW] | r3[CW];
		end
	end

`ifndef SYNTHESIS
	a_sqrt_align: assert property (@(posedge clk) disable iff (!arst_n) rv == rv_b)
		else $error("square root lanes out of step");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
`endif
endmodule
`default_nettype wire

// File: tb/sv/tb_spline_control_points_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spline_control_points_top
// Self-checking bench for the spline control point pipeline: a directed table
// of waypoint triples, then random triples under several tension settings,
// with random gaps on both stream sides and a scoreboard fed by a predictor.
// ----------------------------------------------------------------------------
module tb_spline_control_points_top;
	localparam int CW      = 16;
	localparam int LAT     = 4 + (CW+1) + (CW+27) + 4;
	localparam int WDOG    = 20000;

	typedef struct packed {
		logic signed [CW-1:0] p2_y, p2_x, p1_y, p1_x, p0_y, p0_x;
	} triple_t;

	typedef struct packed {
		logic              clipped;
		logic signed [CW-1:0] c2_y, c2_x, c1_y, c1_x;
	} ctrl_t;

	typedef struct {
		triple_t t;
		logic    has_exp;
		ctrl_t   e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [scp_pkg::TENSION_BITS-1:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;

	always #1 clk = ~clk;

	spline_control_points_top #(.COORD_WIDTH(CW), .FRAC_BITS(4)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	logic [scp_pkg::TENSION_BITS-1:0] tension_q = scp_pkg::TENSION_RESET;
	ctrl_t ctrl_pending[$];
	int errors = 0;
	int idle_cycles = 0;
	logic timed_out = 1'b0;
	logic rx_stall_long = 1'b0;

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned span(longint ax, longint ay, longint bx, longint by);
		longint unsigned dx, dy;
		dx = (ax >= bx) ? ax - bx : bx - ax;
		dy = (ay >= by) ? ay - by : by - ay;
		return root_floor(dx*dx + dy*dy);
	endfunction

	function automatic longint offset_of(longint chord, longint unsigned f);
		longint unsigned m, r;
		m = (chord < 0) ? -chord : chord;
		r = (m * f + (64'd1 << 23)) >> 24;
		return (chord < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic signed [CW-1:0] clamp(longint v, inout logic clip);
		if (v > 32767) begin
			clip = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			clip = 1'b1;
			return 16'sh8000;
		end
		return v[CW-1:0];
	endfunction

	function automatic ctrl_t control_points(triple_t t, logic [9:0] ten);
		longint x0, y0, x1, y1, x2, y2, cx, cy;
		longint unsigned d01, s, fa, fb, full;
		logic clip;
		ctrl_t c;
		x0 = t.p0_x; y0 = t.p0_y; x1 = t.p1_x; y1 = t.p1_y; x2 = t.p2_x; y2 = t.p2_y;
		d01 = span(x1, y1, x0, y0);
		s = d01 + span(x2, y2, x1, y1);
		fa = 0;
		fb = 0;
		clip = 1'b0;
		cx = x2 - x0;
		cy = y2 - y0;
		if (s != 0) begin
			full = longint'(ten) << 16;
			fa = ((longint'(ten) * d01 << 16) + (s >> 1)) / s;
			if (fa > full) fa = full;
			fb = full - fa;
		end
		c.c1_x = clamp(x1 - offset_of(cx, fa), clip);
		c.c1_y = clamp(y1 - offset_of(cy, fa), clip);
		c.c2_x = clamp(x1 + offset_of(cx, fb), clip);
		c.c2_y = clamp(y1 + offset_of(cy, fb), clip);
		c.clipped = clip;
		return c;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// result side: random stalls, compare against oldest expectation
	always @(posedge clk) begin
		ctrl_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata};
				if (ctrl_pending.size() == 0) begin
					report("unexpected word", got.c1_x, 0);
				end else begin
					want = ctrl_pending.pop_front();
					if (got.c1_x !== want.c1_x) report("c1_x", got.c1_x, want.c1_x);
					if (got.c1_y !== want.c1_y) report("c1_y", got.c1_y, want.c1_y);
					if (got.c2_x !== want.c2_x) report("c2_x", got.c2_x, want.c2_x);
					if (got.c2_y !== want.c2_y) report("c2_y", got.c2_y, want.c2_y);
					if (got.clipped !== want.clipped)
						report("clipped", got.clipped, want.clipped);
				end
			end
			if (rx_stall_long)
				m_axis_tready <= ($urandom_range(0, 9) == 0);
			else
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 199) == 0) rx_stall_long <= ~rx_stall_long;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG && !timed_out) begin
			timed_out <= 1'b1;
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_triple(triple_t t, logic has_exp, ctrl_t e);
		ctrl_t p;
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= t;
		do @(posedge clk); while (!s_axis_tready);
		p = control_points(t, tension_q);
		if (has_exp && p !== e) begin
			$display("table row disagrees with prediction at %0t", $time);
			errors++;
		end
		ctrl_pending.push_back(has_exp ? e : p);
	endtask

	task automatic write_tension(logic [9:0] v);
		s_axis_tvalid <= 1'b0;
		while (ctrl_pending.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tension_q = v;
	endtask

	function automatic logic signed [CW-1:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		row_t rows[$];
		row_t r;
		triple_t t;
		ctrl_t none;
		logic [9:0] tensions[6];
		int mode;
		none = '0;
		// coincident points: both control points are p1
		r.has_exp = 1'b1;
		r.t = '{default: 16'sd100};
		r.e = '{1'b0, 16'sd100, 16'sd100, 16'sd100, 16'sd100};
		rows.push_back(r);
		r.t = '{default: 16'sh8000};
		r.e = '{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
		rows.push_back(r);
		r.t = '{default: 16'sh7fff};
		r.e = '{1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		rows.push_back(r);
		r.has_exp = 1'b0;
		r.e = none;
		r.t = '{16'sh7fff, 16'sh7fff, 16'sh0, 16'sh0, 16'sh8000, 16'sh8000};
		rows.push_back(r);
		r.t = '{16'sh8000, 16'sh8000, 16'sh0, 16'sh0, 16'sh7fff, 16'sh7fff};
		rows.push_back(r);
		r.t = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
		rows.push_back(r);
		r.t = '{16'sd0, 16'sd320, 16'sd0, 16'sd160, 16'sd0, 16'sd0};
		rows.push_back(r);
		r.t = '{16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd5, 16'sd5};
		rows.push_back(r);
		r.t = '{16'shffff, 16'shaaaa, 16'sh5555, 16'sh0f0f, 16'shf0f0, 16'sh1234};
		rows.push_back(r);

		tensions = '{10'd0, 10'd1, 10'd256, 10'd512, 10'd1023, 10'd700};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_triple(rows[i].t, rows[i].has_exp, rows[i].e);
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				write_tension(ph == 6 ? 10'($urandom_range(0, 1023)) : tensions[ph-1]);
				for (int i = 0; i < 5; i++) send_triple(rows[i+3].t, 1'b0, none);
			end
			for (int i = 0; i < 85; i++) begin
				mode = $urandom_range(0, 9);
				t = '0;
				t.p0_x = rnd_coord(mode < 2 ? 0 : (mode < 5 ? 1 : 2));
				t.p0_y = rnd_coord(mode < 2 ? 0 : (mode < 5 ? 1 : 2));
				t.p1_x = rnd_coord(mode == 0 ? 0 : (mode < 5 ? 1 : 2));
				t.p1_y = rnd_coord(mode == 0 ? 0 : (mode < 5 ? 1 : 2));
				t.p2_x = rnd_coord(mode < 2 ? 0 : (mode < 5 ? 1 : 2));
				t.p2_y = rnd_coord(mode < 2 ? 0 : (mode < 5 ? 1 : 2));
				if (mode == 9) t.p2_x = t.p1_x;
				if (mode == 9) t.p2_y = t.p1_y;
				send_triple(t, 1'b0, none);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (ctrl_pending.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: sim.f
rtl/scp_pkg.sv
rtl/scp_isqrt.sv
rtl/scp_div.sv
rtl/spline_control_points_top.sv
tb/sv/tb_spline_control_points_top.sv
